// ===== design/double_ended_queue_unit_macros.svh =====
// ----------------------------------------------------------------------------
// double_ended_queue_unit_macros: assertion shorthands for the queue unit
// Clocked on clk and held off while rst is high.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// condition implies consequence in the same cycle
`define DEQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deq assertion failed");

// condition implies consequence in the next cycle
`define DEQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deq assertion failed");

`endif

// ===== design/deq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants of the double-ended queue unit.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEQ_DEPTH = 16;

  // operation codes carried in the mode field
  typedef enum logic [2:0] {
    MODE_INS_FRONT = 3'd0,
    MODE_INS_REAR  = 3'd1,
    MODE_REM_FRONT = 3'd2,
    MODE_REM_REAR  = 3'd3,
    MODE_DUMP      = 3'd4
  } deq_mode_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } deq_status_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_DUMP
  } deq_state_t;

  // request payload
  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] value;
  } deq_req_t;

  // result payload
  typedef struct packed {
    deq_status_t        status;
    logic signed [31:0] data_out;
    logic               last;
    logic [4:0]         occupancy;
  } deq_res_t;

  // controller to datapath commands
  typedef struct packed {
    logic        latch;     // capture the request
    logic        ins;       // write entry and grow the queue
    logic        rd;        // read the store
    logic        step;      // advance the dump index
    logic        pop;       // shrink the queue after a remove
    logic        emit;      // load the result register
    deq_status_t st;        // status of the emitted result
    logic        use_data;  // result carries read data
    logic        last;      // result closes the request
  } deq_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [2:0] mode;
    logic       empty;
    logic       full;
    logic       dump_last;
  } deq_sts_t;

endpackage

// ===== design/double_ended_queue_unit.sv =====
`timescale 1ns / 1ps
// Insert, unknown mode, or any request refused as full or empty: result loaded from S_EXEC.
// Remove: the store read is registered, so the result is loaded from S_READ, after S_EXEC.
// Dump of N entries: first result loaded from S_DUMP, after S_EXEC, then one per cycle, last marked.
// busy drops as the final result is loaded, so a new request fits in that result's cycle.
// Reset (synchronous, rst high) empties the queue; the store itself is not cleared.
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue on a ring store with insert, remove and dump.
// ----------------------------------------------------------------------------
module double_ended_queue_unit import deq_pkg::*; #(
  parameter int DEPTH = DEQ_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  deq_req_t req,
  output logic     busy,
  output logic     done,
  output deq_res_t res
);

  deq_cmd_t cmd;
  deq_sts_t sts;

  // sequencer
  deq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  // store and result path
  deq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .sts  (sts),
    .done (done),
    .res  (res)
  );

endmodule

// ===== design/deq_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_datapath
// Ring store, head and count registers, dump index and result register.
// ----------------------------------------------------------------------------
`include "double_ended_queue_unit_macros.svh"

module deq_datapath import deq_pkg::*; #(
  parameter int DEPTH = DEQ_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  deq_req_t req,
  input  deq_cmd_t cmd,
  output deq_sts_t sts,
  output logic     done,
  output deq_res_t res
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [2:0]         mode;
  logic signed [31:0] value;
  logic [IW-1:0]      head;
  logic [IW-1:0]      head_next;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [IW-1:0]      idx;
  logic [IW-1:0]      idx_rd;
  logic [IW-1:0]      wr_addr;
  logic [IW-1:0]      rd_addr;
  logic [IW-1:0]      head_dec;
  logic [31:0]        rd_data;
  logic               is_front;
  logic               full;
  logic               empty;

  logic [31:0] mem [DEPTH];

  // ring add: base below DEPTH, offset at most DEPTH
  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] b,
                                             input logic [CW-1:0] o);
    logic [CW:0] s;
    s = (CW+1)'(b) + (CW+1)'(o);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[IW-1:0];
  endfunction

  // latched request
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode  <= req.mode;
      value <= req.value;
    end
  end

  assign is_front = (mode == MODE_INS_FRONT) || (mode == MODE_REM_FRONT);
  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign head_dec = (head == '0) ? IW'(DEPTH - 1) : head - IW'(1);

  // addresses
  assign idx_rd  = cmd.step ? idx + IW'(1) : idx;
  assign wr_addr = is_front ? head_dec : wrap_add(head, count);
  always_comb begin
    priority if (mode == MODE_DUMP) begin
      rd_addr = wrap_add(head, CW'(idx_rd));
    end else if (is_front) begin
      rd_addr = head;
    end else begin
      rd_addr = wrap_add(head, count - CW'(1));
    end
  end

  // head and count updates
  always_comb begin
    head_next  = head;
    count_next = count;
    if (cmd.ins) begin
      head_next  = is_front ? head_dec : head;
      count_next = count + CW'(1);
    end else if (cmd.pop) begin
      head_next  = is_front ? wrap_add(head, CW'(1)) : head;
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  // dump walk index
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      idx <= '0;
    end else if (cmd.step) begin
      idx <= idx + IW'(1);
    end
  end

  // ring store
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      mem[wr_addr] <= value;
    end
    if (cmd.rd) begin
      rd_data <= mem[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res.status    <= cmd.st;
      res.data_out  <= cmd.use_data ? rd_data : '0;
      res.last      <= cmd.last;
      res.occupancy <= 5'(count_next);
    end
  end

  assign sts.mode      = mode;
  assign sts.empty     = empty;
  assign sts.full      = full;
  assign sts.dump_last = ((CW'(idx) + CW'(1)) == count);

  // checks
  `DEQ_ASSERT_NOW(a_count_max, 1'b1, count <= CW'(DEPTH))
  `DEQ_ASSERT_NOW(a_no_ins_full, cmd.ins, !full)
  `DEQ_ASSERT_NOW(a_no_pop_empty, cmd.pop, !empty)
  `DEQ_ASSERT_NEXT(a_dump_continues, done && !res.last, done)

endmodule

// ===== design/deq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer for one request: decode, store access and result emission.
// ----------------------------------------------------------------------------
module deq_ctrl import deq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  deq_sts_t sts,
  output logic     busy,
  output deq_cmd_t cmd
);

  deq_state_t state;
  deq_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_IDLE;
        if (!sts.empty) begin
          if (sts.mode == MODE_REM_FRONT || sts.mode == MODE_REM_REAR) begin
            state_next = S_READ;
          end else if (sts.mode == MODE_DUMP) begin
            state_next = S_DUMP;
          end
        end
      end
      S_READ: state_next = S_IDLE;
      S_DUMP: begin
        if (sts.dump_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.st   = ST_OK;
    cmd.last = 1'b1;
    busy     = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        cmd.latch = start;
      end
      S_EXEC: begin
        unique case (sts.mode)
          MODE_INS_FRONT, MODE_INS_REAR: begin
            cmd.emit = 1'b1;
            if (sts.full) begin
              cmd.st = ST_FULL;
            end else begin
              cmd.ins = 1'b1;
            end
          end
          MODE_REM_FRONT, MODE_REM_REAR, MODE_DUMP: begin
            if (sts.empty) begin
              cmd.emit = 1'b1;
              cmd.st   = ST_EMPTY;
            end else begin
              cmd.rd = 1'b1;
            end
          end
          default: cmd.emit = 1'b1;
        endcase
      end
      S_READ: begin
        cmd.emit     = 1'b1;
        cmd.use_data = 1'b1;
        cmd.pop      = 1'b1;
      end
      S_DUMP: begin
        cmd.emit     = 1'b1;
        cmd.use_data = 1'b1;
        cmd.last     = sts.dump_last;
        cmd.rd       = !sts.dump_last;
        cmd.step     = !sts.dump_last;
      end
      default: cmd.latch = 1'b0;
    endcase
  end

endmodule
